// ----- rtl/bmip_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmip_pkg: shared constants and types of the box-mean image pyramid
// Field widths, level count, result queue sizing and the pipeline records
// that carry one pixel through the per-level stages.
// ----------------------------------------------------------------------------
package bmip_pkg;

  // Largest image side is 2^MAX_SIDE_LOG2; the coarsest level is 2x2.
  localparam int MAX_SIDE_LOG2 = 10;
  localparam int MIN_SIDE_LOG2 = 2;
  localparam int NLEV          = MAX_SIDE_LOG2 - 1;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 4;
  localparam int POS_W  = MAX_SIDE_LOG2;
  localparam int OPOS_W = 9;
  localparam int LVL_W  = 4;
  localparam int SUM_W  = 26;
  localparam int HOLD_W = 25;
  localparam int SUB_W  = $clog2(NLEV);

  // Result bundle queue.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [CFG_W-1:0] SIDE_LOG2_RESET = CFG_W'(10);

  // One pixel on its way through the level stages.
  typedef struct packed {
    logic                           active;
    logic [POS_W-1:0]               row;
    logic [POS_W-1:0]               col;
    logic [SUM_W-1:0]               val;
    logic [LVL_W-1:0]               nres;
    logic [NLEV-1:0][SUM_W-1:0]     sums;
  } stage_t;

  // All results caused by one pixel, waiting for the output port.
  typedef struct packed {
    logic [POS_W-1:0]               row;
    logic [POS_W-1:0]               col;
    logic [LVL_W-1:0]               nres;
    logic [NLEV-1:0][SUM_W-1:0]     sums;
  } bundle_t;

endpackage
`default_nettype wire

// ----- rtl/bmip_pix_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmip_pix_if: input pixel channel
// Valid/ready channel carrying one full-resolution pixel per transaction.
// ----------------------------------------------------------------------------
interface bmip_pix_if import bmip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface
`default_nettype wire

// ----- rtl/bmip_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmip_res_if: pyramid result channel
// Valid/ready channel carrying one pyramid pixel per transaction.
// ----------------------------------------------------------------------------
interface bmip_res_if import bmip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LVL_W-1:0]  level;
  logic [OPOS_W-1:0] out_row;
  logic [OPOS_W-1:0] out_col;
  logic [SUM_W-1:0]  block_sum;
  logic              last;

  modport source (output valid, output level, output out_row, output out_col,
                  output block_sum, output last, input ready);
  modport sink   (input valid, input level, input out_row, input out_col,
                  input block_sum, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/box_mean_image_pyramid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// box_mean_image_pyramid: streaming 2x2 box-sum image pyramid
// Pixels of a square image arrive on pix in raster order. Every pixel that
// closes a 2x2 block at one or more coarser levels yields one transaction per
// closed level on res, in rising level order, with the exact block sum; the
// mean is block_sum >> (2 * level). last marks the final result of a pixel.
// cfg_we writes side_log2 (used clamped to 2..10) and returns the position to
// the origin; frame_start on a pixel does the same for that pixel.
// Throughput: one pixel per cycle while pix.ready is high. Each level is one
// pipeline stage with its own pair-line memory and left-hold register, so
// every stage takes a new pixel each cycle. Results leave at one per cycle
// while res.ready is high; a pixel that closes a block reserves one of eight
// bundle queue slots when it is accepted, and pix.ready falls while all eight
// are reserved. A pixel passes the input register, the level stages and the
// bundle queue before the output register presents its first result on res.
// Reset: position counters zero, side_log2 = 10, pipeline and queue empty.
// Pair-line memory contents are undefined until written; no clearing pass.
// A stall on res holds the result register; the queue keeps absorbing
// bundles until it runs out of free slots.
// ----------------------------------------------------------------------------
module box_mean_image_pyramid import bmip_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bmip_pix_if.sink         pix,
  bmip_res_if.source       res
);

  logic [CFG_W-1:0]  side_log2;
  logic [CFG_W-1:0]  lg_used;
  logic [POS_W:0]    side;
  logic [POS_W-1:0]  row_count;
  logic [POS_W-1:0]  col_count;
  logic [POS_W-1:0]  row_count_next;
  logic [POS_W-1:0]  col_count_next;
  logic [POS_W-1:0]  pos_row;
  logic [POS_W-1:0]  pos_col;
  logic [POS_W:0]    col_inc;
  logic [POS_W:0]    row_inc;
  logic              accept;
  logic              closes;

  stage_t            p   [0:NLEV];
  stage_t            nxt [1:NLEV];
  logic [NLEV:0]     pv;

  bundle_t           queue [0:QDEPTH-1];
  bundle_t           head;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] qcount;
  logic [QCNT_W-1:0] reserved;
  logic              push;
  logic              pop;
  logic              load;
  logic [SUB_W-1:0]  sub;
  logic [LVL_W-1:0]  cur_level;

  logic              out_valid;
  logic [LVL_W-1:0]  out_level;
  logic [OPOS_W-1:0] out_row;
  logic [OPOS_W-1:0] out_col;
  logic [SUM_W-1:0]  out_sum;
  logic              out_last;

  // Clamp the configured side to the supported range.
  always_comb begin
    if (side_log2 < CFG_W'(MIN_SIDE_LOG2)) begin
      lg_used = CFG_W'(MIN_SIDE_LOG2);
    end else if (side_log2 > CFG_W'(MAX_SIDE_LOG2)) begin
      lg_used = CFG_W'(MAX_SIDE_LOG2);
    end else begin
      lg_used = side_log2;
    end
  end

  assign side = (POS_W + 1)'(1) << lg_used;

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    pos_row = pix.frame_start ? '0 : row_count;
    pos_col = pix.frame_start ? '0 : col_count;
    col_inc = {1'b0, pos_col} + (POS_W + 1)'(1);
    row_inc = {1'b0, pos_row} + (POS_W + 1)'(1);
    if (col_inc == side) begin
      col_count_next = '0;
      row_count_next = (row_inc == side) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_count_next = col_inc[POS_W-1:0];
      row_count_next = pos_row;
    end
  end

  // A pixel on an odd row and odd column closes at least the first level.
  assign closes    = pos_row[0] & pos_col[0];
  assign pix.ready = (reserved != QCNT_W'(QDEPTH));
  assign accept    = pix.valid & pix.ready;

  // Configuration and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_log2 <= SIDE_LOG2_RESET;
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_we) begin
      side_log2 <= cfg_wdata;
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Input register of the level pipeline.
  always_ff @(posedge clk) begin
    p[0].active <= 1'b1;
    p[0].row    <= pos_row;
    p[0].col    <= pos_col;
    p[0].val    <= SUM_W'(pix.pixel);
    p[0].nres   <= '0;
    p[0].sums   <= '0;
  end

  // Stage valid bits shift with the pipeline, which never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[NLEV-1:0], accept};
    end
  end

  // One stage per pyramid level.
  for (genvar g = 1; g <= NLEV; g++) begin : g_level
    localparam int AW    = MAX_SIDE_LOG2 - g;
    localparam int DEPTH = 1 << AW;

    logic [SUM_W-1:0]  mem [0:DEPTH-1];
    logic [SUM_W-1:0]  rdata;
    logic [SUM_W-1:0]  pair;
    logic [SUM_W-1:0]  sum;
    logic [HOLD_W-1:0] left_hold;
    logic [POS_W-1:0]  rd_col;
    logic              wr_en;
    logic              hold_en;

    // The read is issued one stage ahead so the data meets the pixel.
    if (g == 1) begin : g_rd_first
      assign rd_col = pos_col;
    end else begin : g_rd_pipe
      assign rd_col = p[g-2].col;
    end

    // Pair sums and the level decision for the pixel in the previous stage.
    always_comb begin
      pair    = SUM_W'(left_hold) + p[g-1].val;
      sum     = rdata + pair;
      wr_en   = 1'b0;
      hold_en = 1'b0;
      nxt[g]  = p[g-1];
      nxt[g].active = 1'b0;
      if (pv[g-1] && p[g-1].active && (LVL_W'(g) < lg_used)) begin
        if (!p[g-1].col[g-1]) begin
          hold_en = 1'b1;
        end else if (!p[g-1].row[g-1]) begin
          wr_en = 1'b1;
        end else begin
          nxt[g].active    = 1'b1;
          nxt[g].val       = sum;
          nxt[g].sums[g-1] = sum;
          nxt[g].nres      = LVL_W'(g);
        end
      end
    end

    // Pair-line memory of this level, one entry per block column.
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[p[g-1].col[POS_W-1:g]] <= pair;
      end
      rdata <= mem[rd_col[POS_W-1:g]];
    end

    // Left element of the current horizontal pair.
    always_ff @(posedge clk) begin
      if (hold_en) begin
        left_hold <= p[g-1].val[HOLD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      p[g] <= nxt[g];
    end
  end

  // Bundle queue between the pipeline and the output register.
  assign push      = pv[NLEV] && (p[NLEV].nres != '0);
  assign head      = queue[rd_ptr];
  assign cur_level = LVL_W'(sub) + LVL_W'(1);
  assign load      = (qcount != '0) && (!out_valid || res.ready);
  assign pop       = load && (cur_level == head.nres);

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{row: p[NLEV].row, col: p[NLEV].col,
                         nres: p[NLEV].nres, sums: p[NLEV].sums};
    end
  end

  // Queue pointers, fill count and slot reservations.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      qcount   <= '0;
      reserved <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      qcount   <= qcount + QCNT_W'(push) - QCNT_W'(pop);
      reserved <= reserved + QCNT_W'(accept && closes) - QCNT_W'(pop);
    end
  end

  // Output register control: one result transaction per cycle while res.ready is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= pop ? '0 : sub + SUB_W'(1);
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload, taken from the head bundle.
  always_ff @(posedge clk) begin
    if (load) begin
      out_level <= cur_level;
      out_row   <= OPOS_W'(head.row >> cur_level);
      out_col   <= OPOS_W'(head.col >> cur_level);
      out_sum   <= head.sums[sub];
      out_last  <= pop;
    end
  end

  assign res.valid     = out_valid;
  assign res.level     = out_level;
  assign res.out_row   = out_row;
  assign res.out_col   = out_col;
  assign res.block_sum = out_sum;
  assign res.last      = out_last;

endmodule
`default_nettype wire

// ----- sim/tb_box_mean_image_pyramid.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_mean_image_pyramid: self-checking testbench of the box-sum pyramid
// Streams grey pixels into the block and predicts every pyramid pixel it must
// produce. The prediction keeps its own position counters, pair-line store
// and left-hold values. Results are checked field by field in arrival order.
// Directed tests cover side clamping, extreme sums and a frame restart.
// Random frames follow at several image sides. A back-pressure test holds the
// result channel off long enough to stall the pixel input.
// ----------------------------------------------------------------------------
module tb_box_mean_image_pyramid;
  import bmip_pkg::*;

  localparam int MAX_GAP         = 15;
  localparam int SETTLE_CYCLES   = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 270;
  localparam int LINE_DEPTH      = 1 << MAX_SIDE_LOG2;

  // One expected pyramid pixel.
  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [OPOS_W-1:0] row;
    logic [OPOS_W-1:0] col;
    logic [SUM_W-1:0]  bsum;
    logic              last;
  } pyr_pix_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bmip_pix_if pix_ch ();
  bmip_res_if res_ch ();

  box_mean_image_pyramid DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .pix(pix_ch),
    .res(res_ch)
  );

  // Prediction state: configured side, next position and the sum stores.
  logic [CFG_W-1:0] side_cfg;
  logic [POS_W-1:0] pos_row;
  logic [POS_W-1:0] pos_col;
  logic [SUM_W-1:0] pair_line_mem [LINE_DEPTH];
  logic [SUM_W-1:0] left_val [NLEV];
  pyr_pix_t         pending_sums [$];

  int err_cnt        = 0;
  int tx_gap_max     = MAX_GAP;
  int rx_gap_max     = MAX_GAP;
  int rx_hold_cycles = 0;

  always #5 clk = ~clk;

  // The side in use is the register value clamped to the supported range.
  function automatic int unsigned used_side_log2(input logic [CFG_W-1:0] v);
    if (v < MIN_SIDE_LOG2) return MIN_SIDE_LOG2;
    if (v > MAX_SIDE_LOG2) return MAX_SIDE_LOG2;
    return v;
  endfunction

  // Advance the pyramid by one pixel and queue every block sum it closes.
  task automatic predict_block_sums(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      lg, side, r0, c0, r, c, idx, k;
    int               n;
    logic [SUM_W-1:0] val;
    logic [SUM_W-1:0] pair;
    pyr_pix_t         item;
    lg = used_side_log2(side_cfg);
    side = 1 << lg;
    n = 0;
    val = SUM_W'(px);
    if (fs) begin
      pos_row = '0;
      pos_col = '0;
    end
    r0 = pos_row & (side - 1);
    c0 = pos_col & (side - 1);
    for (k = 1; k < lg; k++) begin
      r = r0 >> (k - 1);
      c = c0 >> (k - 1);
      idx = ((side - (side >> (k - 1))) + (c >> 1)) & (LINE_DEPTH - 1);
      // An even column only parks its value as the left half of a pair.
      if ((c & 1) == 0) begin
        left_val[k - 1] = val;
        break;
      end
      pair = left_val[k - 1] + val;
      // An even row stores the pair for the row below.
      if ((r & 1) == 0) begin
        pair_line_mem[idx] = pair;
        break;
      end
      val = pair_line_mem[idx] + pair;
      item.level = LVL_W'(k);
      item.row   = OPOS_W'(r >> 1);
      item.col   = OPOS_W'(c >> 1);
      item.bsum  = val;
      item.last  = 1'b0;
      pending_sums = {pending_sums, item};
      n++;
    end
    if (n > 0) pending_sums[pending_sums.size() - 1].last = 1'b1;
    c0++;
    if (c0 >= side) begin
      c0 = 0;
      r0 = (r0 + 1) & (side - 1);
    end
    pos_col = POS_W'(c0);
    pos_row = POS_W'(r0);
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Each accepted pixel transaction moves the prediction forward.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready)
      predict_block_sums(pix_ch.pixel, pix_ch.frame_start);
  end

  // Each accepted result transaction is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    pyr_pix_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: level %0d row %0d col %0d sum %0d",
               res_ch.level, res_ch.out_row, res_ch.out_col, res_ch.block_sum);
        err_cnt++;
      end else begin
        want = pending_sums.pop_front();
        check_field("level", want.level, res_ch.level);
        check_field("out_row", want.row, res_ch.out_row);
        check_field("out_col", want.col, res_ch.out_col);
        check_field("block_sum", want.bsum, res_ch.block_sum);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Offer one pixel after a random gap and wait until it is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= px;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Random pixels in frames of the given area. Frame boundaries sometimes
  // carry frame_start and sometimes rely on the counters wrapping; a noisy
  // stream also restarts frames at random points.
  task automatic send_stream(input int count, input int area, input bit noisy);
    int   i, pos;
    logic fs;
    pos = 0;
    for (i = 0; i < count; i++) begin
      fs = (pos == 0) ? ((i == 0) || ($urandom_range(0, 1) == 1)) : 1'b0;
      if (noisy && $urandom_range(0, 39) == 0) begin
        fs = 1'b1;
        pos = 0;
      end
      send_pixel(PIX_W'($urandom_range(0, 255)), fs);
      pos = (pos + 1) % area;
    end
  endtask

  // Stop offering and let every expected result and the pipeline drain.
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the block also returns to the frame origin.
  task automatic write_side_log2(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    side_cfg = v;
    pos_row  = '0;
    pos_col  = '0;
  endtask

  // Reset side, then the top of the register field clamped down.
  task automatic test_reset_side();
    send_pixel(8'hA5, 1'b1);
    send_pixel(8'h5A, 1'b0);
    drain_results();
    write_side_log2(CFG_W'(15));
    send_pixel(8'hFF, 1'b0);
    drain_results();
    write_side_log2(CFG_W'(MAX_SIDE_LOG2));
    send_pixel(8'h00, 1'b1);
    drain_results();
  endtask

  // Zero is clamped up to the 4x4 image; full-scale and zero block sums.
  task automatic test_min_side_extremes();
    int i;
    write_side_log2(CFG_W'(0));
    for (i = 0; i < 16; i++)
      send_pixel((i < 8) ? 8'hFF : 8'h00, i == 0);
    drain_results();
  endtask

  // A frame start in the middle of a frame drops the partial blocks.
  task automatic test_frame_restart();
    int i;
    write_side_log2(CFG_W'(MIN_SIDE_LOG2));
    for (i = 0; i < 3; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
    for (i = 0; i < 6; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
    drain_results();
  endtask

  // Random frames over several sides and idling mixes.
  task automatic test_random_frames();
    int               sent, pick, cnt, side;
    logic [CFG_W-1:0] v;
    // One whole 16x16 frame reaches the third level.
    write_side_log2(CFG_W'(4));
    send_stream(256, 256, 1'b0);
    drain_results();
    sent = 256;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) v = CFG_W'($urandom_range(0, 1));
      else if (pick <= 4) v = CFG_W'(2);
      else if (pick <= 8) v = CFG_W'(3);
      else v = CFG_W'($urandom_range(MAX_SIDE_LOG2, 15));
      write_side_log2(v);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      side = 1 << used_side_log2(v);
      if (side > 8) begin
        // Large sides stay on the first row: no results, only state changes.
        cnt = $urandom_range(2, 12);
      end else begin
        cnt = side * side * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) cnt -= $urandom_range(1, side);
      end
      send_stream(cnt, side * side, 1'b1);
      drain_results();
      sent += cnt;
    end
    tx_gap_max = MAX_GAP;
    rx_gap_max = MAX_GAP;
  endtask

  // The receiver holds off while pixels keep coming, so the bundle queue
  // fills and the pixel input must stall.
  task automatic test_backpressure();
    write_side_log2(CFG_W'(MIN_SIDE_LOG2));
    tx_gap_max = 0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    send_stream(64, 16, 1'b0);
    drain_results();
    tx_gap_max = MAX_GAP;
  endtask

  initial begin
    cfg_we             <= 1'b0;
    cfg_wdata          <= SIDE_LOG2_RESET;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    side_cfg = SIDE_LOG2_RESET;
    pos_row  = '0;
    pos_col  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_side();
    test_min_side_extremes();
    test_frame_restart();
    test_random_frames();
    test_backpressure();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
